FILE: rtl/core/hash_vertex_jitter_top_macros.svh
// assertion macros shared by the vertex jitter rtl
`ifndef HASH_VERTEX_JITTER_TOP_MACROS_SVH
`define HASH_VERTEX_JITTER_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define HVJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("hvj assertion failed");

// next-cycle implication, checked outside reset
`define HVJ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("hvj assertion failed");

`endif

FILE: rtl/core/hvj_pkg.sv
// shared types, constants and helpers of the vertex jitter block
package hvj_pkg;

  localparam int NumStages = 6;

  localparam logic [31:0] MulDraw   = 32'h9e3779b9;
  localparam logic [31:0] MulVertex = 32'h85ebca6b;
  localparam logic [31:0] MulTick   = 32'hc2b2ae35;
  localparam logic [31:0] MulFin1   = 32'h7feb352d;
  localparam logic [31:0] MulFin2   = 32'h846ca68b;
  localparam logic [31:0] SaltX     = 32'h68bc21eb;
  localparam logic [31:0] SaltY     = 32'h02e5be93;

  typedef enum logic [2:0] {
    RegSeed = 3'd0,
    RegDraw = 3'd1,
    RegTick = 3'd2,
    RegAmpX = 3'd3,
    RegAmpY = 3'd4
  } hvj_reg_e;

  typedef struct packed {
    logic [31:0] seed;
    logic [31:0] draw;
    logic [31:0] tick;
  } hvj_cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } hvj_ctrl_t;

  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

FILE: rtl/core/hash_vertex_jitter_top.sv
// vertex jitter top level: config registers, stage valids and two axis datapaths
//
// usage: vertices enter on the s_ stream (index, x, y in signed q16.16) and leave
// on the m_ stream with both coordinates jittered and a saturation flag in tuser.
// seed, draw number, tick and the two amplitudes are set over the cfg channel,
// which is always ready; write them while no vertex is in flight.
// throughput: one vertex per cycle while m_tready_i is high, as every one of the six
// register stages (input capture, seed mix, two finalizer multiplies, the amplitude
// multiply and the rounding add with saturation) advances in the same cycle.
// reset: clears all stage valid bits and sets every config register to zero.
// stall: when m_tready_i is low the last stage holds its result, earlier stages
// keep filling their bubbles, and s_tready_o drops only once all six stages hold
// a vertex; nothing is dropped or repeated.
`include "hash_vertex_jitter_top_macros.svh"

module hash_vertex_jitter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [79:0] s_tdata_i,   // vertex_index[15:0], x_in[47:16], y_in[79:48]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // x_out[31:0], y_out[63:32]
  output logic [0:0]  m_tuser_o,   // overflow[0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int N = hvj_pkg::NumStages;

  hvj_pkg::hvj_cfg_t  cfg_q;
  logic signed [31:0] amp_x_q, amp_y_q;
  logic [N-1:0]       valid_q, valid_d, ready;
  hvj_pkg::hvj_ctrl_t ctrl;
  logic signed [31:0] x_out, y_out;
  logic               ovf_x, ovf_y;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      amp_x_q <= '0;
      amp_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hvj_pkg::RegSeed: cfg_q.seed <= cfg_data_i;
        hvj_pkg::RegDraw: cfg_q.draw <= cfg_data_i;
        hvj_pkg::RegTick: cfg_q.tick <= cfg_data_i;
        hvj_pkg::RegAmpX: amp_x_q    <= cfg_data_i;
        hvj_pkg::RegAmpY: amp_y_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage takes new data when empty or when its successor moves
  always_comb begin
    ready[N-1] = !valid_q[N-1] || m_tready_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
    valid_d[0] = ready[0] ? s_tvalid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = ready[k] ? valid_q[k-1] : valid_q[k];
    end
    ctrl.load = ready;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  hvj_axis u_axis_x (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .salt_i  (hvj_pkg::SaltX),
    .amp_i   (amp_x_q),
    .vtx_i   (s_tdata_i[15:0]),
    .coord_i (s_tdata_i[47:16]),
    .coord_o (x_out),
    .ovf_o   (ovf_x)
  );

  hvj_axis u_axis_y (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .salt_i  (hvj_pkg::SaltY),
    .amp_i   (amp_y_q),
    .vtx_i   (s_tdata_i[15:0]),
    .coord_i (s_tdata_i[79:48]),
    .coord_o (y_out),
    .ovf_o   (ovf_y)
  );

  assign s_tready_o   = ready[0];
  assign m_tvalid_o   = valid_q[N-1];
  assign m_tdata_o    = {y_out, x_out};
  assign m_tuser_o[0] = ovf_x | ovf_y;

  `HVJ_ASSERT_NXT(a_accept_fills_first, clk_i, rst_ni, s_tvalid_i && s_tready_o, valid_q[0])
  `HVJ_ASSERT_IMP(a_full_stall_blocks, clk_i, rst_ni, (&valid_q) && !m_tready_i, !s_tready_o)
  `HVJ_ASSERT_NXT(a_occupancy, clk_i, rst_ni, 1'b1,
    $countones(valid_q) == $countones($past(valid_q))
      + $past(s_tvalid_i && s_tready_o) - $past(m_tvalid_o && m_tready_i))
  `HVJ_ASSERT_IMP(a_ovf_means_clamp, clk_i, rst_ni, m_tvalid_o && m_tuser_o[0],
    (x_out == 32'sh7fffffff) || (x_out == 32'sh80000000)
      || (y_out == 32'sh7fffffff) || (y_out == 32'sh80000000))

endmodule

FILE: rtl/core/hvj_axis.sv
// one axis of the jitter datapath: hash, scale by amplitude, add and saturate
module hvj_axis (
  input  logic                clk_i,
  input  hvj_pkg::hvj_ctrl_t  ctrl_i,
  input  hvj_pkg::hvj_cfg_t   cfg_i,
  input  logic         [31:0] salt_i,
  input  logic signed  [31:0] amp_i,
  input  logic         [15:0] vtx_i,
  input  logic signed  [31:0] coord_i,
  output logic signed  [31:0] coord_o,
  output logic                ovf_o
);

  logic        [15:0] vtx_q;
  logic signed [31:0] c1_q, c2_q, c3_q, c4_q, c5_q;
  logic        [31:0] h1_q, h2_q, h4_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] out_q;
  logic               ovf_q;

  logic        [31:0] h0, h1_d, h2_d, h3, h4_d, h5;
  logic signed [31:0] frac;
  logic signed [63:0] prod_d, rnd;
  logic signed [32:0] delta;
  logic signed [33:0] sum;
  logic signed [31:0] out_d;
  logic               ovf_d;

  always_comb begin
    h0 = cfg_i.seed
       ^ hvj_pkg::mul_lo(cfg_i.draw + 32'd1, hvj_pkg::MulDraw)
       ^ hvj_pkg::mul_lo({16'd0, vtx_q} + 32'd1, hvj_pkg::MulVertex)
       ^ hvj_pkg::mul_lo(cfg_i.tick, hvj_pkg::MulTick)
       ^ salt_i;
    h1_d = h0 ^ (h0 >> 16);
  end

  assign h2_d = hvj_pkg::mul_lo(h1_q, hvj_pkg::MulFin1);

  always_comb begin
    h3   = h2_q ^ (h2_q >> 15);
    h4_d = hvj_pkg::mul_lo(h3, hvj_pkg::MulFin2);
  end

  // hash minus 2^31 as a signed fraction
  always_comb begin
    h5     = h4_q ^ (h4_q >> 16);
    frac   = signed'({~h5[31], h5[30:0]});
    prod_d = frac * amp_i;
  end

  // round half up on the 2^31 scale, then clamp to 32 bits
  always_comb begin
    rnd   = prod_q + 64'sd1073741824;
    delta = rnd[63:31];
    sum   = {{2{c5_q[31]}}, c5_q} + {delta[32], delta};
    ovf_d = (sum[33:31] != 3'b000) && (sum[33:31] != 3'b111);
    if (!ovf_d) begin
      out_d = sum[31:0];
    end else if (sum[33]) begin
      out_d = 32'sh80000000;
    end else begin
      out_d = 32'sh7fffffff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      vtx_q <= vtx_i;
      c1_q  <= coord_i;
    end
    if (ctrl_i.load[1]) begin
      h1_q <= h1_d;
      c2_q <= c1_q;
    end
    if (ctrl_i.load[2]) begin
      h2_q <= h2_d;
      c3_q <= c2_q;
    end
    if (ctrl_i.load[3]) begin
      h4_q <= h4_d;
      c4_q <= c3_q;
    end
    if (ctrl_i.load[4]) begin
      prod_q <= prod_d;
      c5_q   <= c4_q;
    end
    if (ctrl_i.load[5]) begin
      out_q <= out_d;
      ovf_q <= ovf_d;
    end
  end

  assign coord_o = out_q;
  assign ovf_o   = ovf_q;

endmodule

FILE: bench/tb_top.sv
// self-checking bench for the vertex jitter block: directed table, then random phases
`timescale 1ns / 1ps

module tb_top;

  localparam int NumDirRows = 18;
  localparam int NumPhases  = 9;
  localparam int PhaseItems = 150;
  localparam int CycleLimit = 600000;
  localparam int MaxPrinted = 50;

  // indexes past the last register, writes there must change nothing
  localparam logic [2:0] RegFirstUnused = 3'd5;
  localparam logic [2:0] RegLastUnused  = 3'd7;

  typedef struct packed {
    logic [31:0]        seed;
    logic [31:0]        draw;
    logic [31:0]        tick;
    logic signed [31:0] amp_x;
    logic signed [31:0] amp_y;
  } jitter_regs_t;

  typedef struct packed {
    logic [15:0]        vtx;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } jitter_vtx_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               ovf;
  } jitter_res_t;

  typedef struct packed {
    jitter_regs_t regs;
    jitter_vtx_t  vert;
    logic         typed;
    jitter_res_t  res;
  } jitter_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [79:0] s_tdata_i   = '0;   // vertex_index[15:0], x_in[47:16], y_in[79:48]
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [63:0] m_tdata_o;          // x_out[31:0], y_out[63:32]
  logic [0:0]  m_tuser_o;          // overflow[0]
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  jitter_regs_t regs_shadow = '0;
  jitter_res_t  jitter_expect_q[$];
  jitter_row_t  dir_rows[NumDirRows];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           sink_gap       = 0;
  bit           idle_en        = 1'b0;

  hash_vertex_jitter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [31:0] lane_hash(input jitter_regs_t r, input logic [15:0] vtx,
                                            input logic [31:0] salt);
    logic [31:0] h;
    logic [31:0] vtx_p1;
    logic [31:0] draw_p1;
    vtx_p1  = {16'd0, vtx} + 32'd1;   // no wrap at the top index
    draw_p1 = r.draw + 32'd1;
    h = r.seed ^ (draw_p1 * hvj_pkg::MulDraw) ^ (vtx_p1 * hvj_pkg::MulVertex)
      ^ (r.tick * hvj_pkg::MulTick) ^ salt;
    h = h ^ (h >> 16);
    h = h * hvj_pkg::MulFin1;
    h = h ^ (h >> 15);
    h = h * hvj_pkg::MulFin2;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // returns {saturated, coordinate}
  function automatic logic [32:0] jitter_coord(input logic signed [31:0] coord,
                                               input logic signed [31:0] amp,
                                               input logic [31:0] h);
    longint frac;
    longint prod;
    longint delta;
    longint sum;
    frac  = longint'({32'd0, h}) - 64'sd2147483648;
    prod  = frac * longint'(amp);
    // round half up: floor((prod + 2^30) / 2^31)
    delta = (prod + 64'sd1073741824) >>> 31;
    sum   = longint'(coord) + delta;
    if (sum > 64'sd2147483647) begin
      return {1'b1, 32'h7fffffff};
    end else if (sum < -64'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, sum[31:0]};
  endfunction

  function automatic jitter_res_t predict_jitter(input jitter_regs_t r, input jitter_vtx_t v);
    logic [32:0] xs;
    logic [32:0] ys;
    jitter_res_t res;
    xs = jitter_coord(v.x, r.amp_x, lane_hash(r, v.vtx, hvj_pkg::SaltX));
    ys = jitter_coord(v.y, r.amp_y, lane_hash(r, v.vtx, hvj_pkg::SaltY));
    res.x   = xs[31:0];
    res.y   = ys[31:0];
    res.ovf = xs[32] | ys[32];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      hvj_pkg::RegSeed: regs_shadow.seed  = data;
      hvj_pkg::RegDraw: regs_shadow.draw  = data;
      hvj_pkg::RegTick: regs_shadow.tick  = data;
      hvj_pkg::RegAmpX: regs_shadow.amp_x = data;
      hvj_pkg::RegAmpY: regs_shadow.amp_y = data;
      default: ;
    endcase
  endtask

  // leaves cfg_valid_i high between writes so it never toggles within a step
  task automatic program_regs(input jitter_regs_t r);
    write_reg(hvj_pkg::RegSeed, r.seed);
    write_reg(hvj_pkg::RegDraw, r.draw);
    write_reg(hvj_pkg::RegTick, r.tick);
    write_reg(hvj_pkg::RegAmpX, r.amp_x);
    write_reg(hvj_pkg::RegAmpY, r.amp_y);
    write_reg(3'($urandom_range(RegFirstUnused, RegLastUnused)), $urandom());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    while (jitter_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_vertex(input jitter_vtx_t v, input bit typed, input jitter_res_t typed_res);
    jitter_res_t want_res;
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {v.y, v.x, v.vtx};
    do @(posedge clk_i); while (!s_tready_o);
    want_res = typed ? typed_res : predict_jitter(regs_shadow, v);
    jitter_expect_q = {jitter_expect_q, want_res};
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hffffffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_amp();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return 32'h1;
      2:       return 32'hffffffff;
      3:       return 32'h7fffffff;
      4:       return 32'h80000000;
      5:       return 32'h00010000;
      6:       return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7fffffff - $urandom_range(0, 255);
      1:       return 32'h80000000 + $urandom_range(0, 255);
      2:       return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return $urandom();
    endcase
  endfunction

  always @(posedge clk_i) begin
    jitter_res_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (jitter_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = jitter_expect_q.pop_front();
        if (m_tdata_o[31:0] !== want.x)
          report_mismatch($sformatf("x_out %h, want %h", m_tdata_o[31:0], want.x));
        if (m_tdata_o[63:32] !== want.y)
          report_mismatch($sformatf("y_out %h, want %h", m_tdata_o[63:32], want.y));
        if (m_tuser_o[0] !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", m_tuser_o[0], want.ovf));
      end
    end
    if (sink_gap != 0) begin
      sink_gap--;
      m_tready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      sink_gap = $urandom_range(0, 16);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    jitter_regs_t r;
    jitter_vtx_t  v;
    dir_rows = '{
      // reset values: zero amplitude leaves the vertex untouched
      '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '{16'h0000, 32'h0, 32'h0},
        1'b1, '{32'h0, 32'h0, 1'b0}},
      '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '{16'hffff, 32'h7fffffff, 32'h80000000},
        1'b1, '{32'h7fffffff, 32'h80000000, 1'b0}},
      '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}, '{16'h1234, 32'h80000000, 32'h7fffffff},
        1'b1, '{32'h80000000, 32'h7fffffff, 1'b0}},
      // all-ones seed, draw and tick, still zero amplitude
      '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0},
        '{16'hffff, 32'h12345678, 32'hffffffff}, 1'b1, '{32'h12345678, 32'hffffffff, 1'b0}},
      '{'{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0},
        '{16'h0000, 32'h80000000, 32'h00000001}, 1'b1, '{32'h80000000, 32'h00000001, 1'b0}},
      // full-scale amplitudes on edge and zero coordinates, saturation either way
      '{'{32'h1, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000},
        '{16'h0000, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
      '{'{32'h1, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000},
        '{16'h0001, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
      '{'{32'h1, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000},
        '{16'h0002, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
      '{'{32'h1, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000},
        '{16'h0003, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
      '{'{32'h0badf00d, 32'h7, 32'hffffffff, 32'h80000000, 32'h7fffffff},
        '{16'hfffe, 32'h80000000, 32'h7fffffff}, 1'b0, '0},
      '{'{32'h0badf00d, 32'h7, 32'hffffffff, 32'h80000000, 32'h7fffffff},
        '{16'hffff, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
      '{'{32'h0badf00d, 32'h7, 32'hffffffff, 32'h80000000, 32'h7fffffff},
        '{16'h8000, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h0badf00d, 32'h7, 32'hffffffff, 32'h80000000, 32'h7fffffff},
        '{16'h0001, 32'h80000000, 32'h80000000}, 1'b0, '0},
      // unit lsb amplitudes exercise the half-way rounding, then 2^16 and full-scale ones
      '{'{32'h0, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff},
        '{16'h0005, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'h0, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff},
        '{16'h0006, 32'h7fffffff, 32'h80000000}, 1'b0, '0},
      '{'{32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'h00010000, 32'h00010000},
        '{16'haaaa, 32'h00010000, 32'hfffe0000}, 1'b0, '0},
      '{'{32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'h00010000, 32'h00010000},
        '{16'h5555, 32'h0, 32'h0}, 1'b0, '0},
      '{'{32'hffffffff, 32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff},
        '{16'h0000, 32'h80000000, 32'h7fffffff}, 1'b0, '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    idle_en = 1'b1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].regs != regs_shadow) begin
        drain_results();
        program_regs(dir_rows[i].regs);
      end
      send_vertex(dir_rows[i].vert, dir_rows[i].typed, dir_rows[i].res);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      r.seed  = rand_word();
      r.draw  = rand_word();
      r.tick  = rand_word();
      r.amp_x = rand_amp();
      r.amp_y = rand_amp();
      program_regs(r);
      // quiet handshakes on the closing phases
      idle_en = (p == 0) || ((p < NumPhases - 2) && ($urandom_range(0, 3) != 0));
      for (int n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 3))
          0:       v.vtx = 16'($urandom_range(0, 15));
          1:       v.vtx = 16'(16'hffff - $urandom_range(0, 15));
          default: v.vtx = 16'($urandom());
        endcase
        v.x = rand_coord();
        v.y = rand_coord();
        send_vertex(v, 1'b0, '0);
      end
    end

    drain_results();
    repeat (hvj_pkg::NumStages * 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
